[rtl/ofv_pkg.sv]
// shared types and constants for the face-vertex token parser
`default_nettype none
package ofv_pkg;

  localparam int unsigned INDEX_BITS = 24;
  localparam int unsigned MAG_BITS   = INDEX_BITS + 1;
  localparam int unsigned COUNT_BITS = 25;
  localparam int unsigned ADDR_BITS  = 4;
  localparam int unsigned DATA_BITS  = 32;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [3:0] RADIX      = 4'd10;

  localparam logic [1:0] REG_POS_COUNT = 2'd0;
  localparam logic [1:0] REG_TEX_COUNT = 2'd1;
  localparam logic [1:0] REG_NRM_COUNT = 2'd2;

  typedef enum logic [1:0] {
    FLD_POS,
    FLD_TEX,
    FLD_NRM
  } ofv_fld_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       token_end;
  } ofv_req_t;

  typedef struct packed {
    logic                  token_ok;
    logic [INDEX_BITS-1:0] position_index;
    logic                  texcoord_present;
    logic [INDEX_BITS-1:0] texcoord_index;
    logic                  normal_present;
    logic [INDEX_BITS-1:0] normal_index;
  } ofv_res_t;

  typedef struct packed {
    logic                ok;
    logic                neg;
    logic [MAG_BITS-1:0] mag;
  } ofv_field_t;

  typedef struct packed {
    ofv_field_t pos;
    ofv_field_t tex;
    ofv_field_t nrm;
  } ofv_tok_t;

  typedef struct packed {
    logic                  present;
    logic [INDEX_BITS-1:0] index;
  } ofv_idx_t;

endpackage
`default_nettype wire

[rtl/obj_face_vertex_token_parser_unit.sv]
// top level: register port, token parser, index resolve and result register
// One character is taken per cycle, with no bubbles between tokens, unless the
// consumer stalls; the character that carries the end mark yields its result
// through a token register and a result register, each of which holds while
// the consumer stalls. The per-character step (multiply-by-ten accumulate with
// saturation) is the longest path and sets the one-item-per-cycle rate. The
// three count registers sit on an APB-style port at byte addresses 0, 4 and 8;
// the user must write them only while no token is in flight (not enforced).
`default_nettype none
module obj_face_vertex_token_parser_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire ofv_pkg::ofv_req_t               in_req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output ofv_pkg::ofv_res_t                    out_res_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ofv_pkg::ADDR_BITS-1:0]   paddr,
  input  wire logic [ofv_pkg::DATA_BITS-1:0]   pwdata,
  output logic [ofv_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready
);
  import ofv_pkg::*;

  logic [COUNT_BITS-1:0] pos_cnt_q;
  logic [COUNT_BITS-1:0] tex_cnt_q;
  logic [COUNT_BITS-1:0] nrm_cnt_q;
  logic                  cfg_wr;

  logic     accept;
  logic     mid_adv;
  logic     out_adv;
  logic     mid_valid_q;
  ofv_tok_t mid_q;
  ofv_tok_t tok;
  ofv_idx_t pos_idx;
  ofv_idx_t tex_idx;
  ofv_idx_t nrm_idx;
  ofv_res_t res_d;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_cnt_q <= '0;
      tex_cnt_q <= '0;
      nrm_cnt_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_POS_COUNT: pos_cnt_q <= pwdata[COUNT_BITS-1:0];
        REG_TEX_COUNT: tex_cnt_q <= pwdata[COUNT_BITS-1:0];
        REG_NRM_COUNT: nrm_cnt_q <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POS_COUNT: prdata = DATA_BITS'(pos_cnt_q);
      REG_TEX_COUNT: prdata = DATA_BITS'(tex_cnt_q);
      REG_NRM_COUNT: prdata = DATA_BITS'(nrm_cnt_q);
      default:       prdata = '0;
    endcase
  end

  // pipeline control
  assign out_adv    = !out_valid_o || out_ready_i;
  assign mid_adv    = !mid_valid_q || out_adv;
  assign in_ready_o = mid_adv;
  assign accept     = in_valid_i && in_ready_o;

  ofv_tok_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .tok_o    (tok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (accept && in_req_i.token_end) begin
      mid_valid_q <= 1'b1;
    end else if (out_adv) begin
      mid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_req_i.token_end) begin
      mid_q <= tok;
    end
  end

  ofv_resolve u_pos (
    .field_i (mid_q.pos),
    .count_i (pos_cnt_q),
    .idx_o   (pos_idx)
  );

  ofv_resolve u_tex (
    .field_i (mid_q.tex),
    .count_i (tex_cnt_q),
    .idx_o   (tex_idx)
  );

  ofv_resolve u_nrm (
    .field_i (mid_q.nrm),
    .count_i (nrm_cnt_q),
    .idx_o   (nrm_idx)
  );

  // texture and normal only count once the position field parsed
  always_comb begin
    res_d = '0;
    res_d.token_ok       = pos_idx.present;
    res_d.position_index = pos_idx.index;
    if (mid_q.pos.ok) begin
      res_d.texcoord_present = tex_idx.present;
      res_d.texcoord_index   = tex_idx.index;
      res_d.normal_present   = nrm_idx.present;
      res_d.normal_index     = nrm_idx.index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_adv) begin
      out_valid_o <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && mid_valid_q) begin
      out_res_o <= res_d;
    end
  end

  a_tex_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.texcoord_present |-> out_res_o.texcoord_index == '0)
    else $error("texture index set without present flag");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !mid_valid_q |=> !out_valid_o)
    else $error("result repeated after it was taken");

endmodule
`default_nettype wire

[rtl/ofv_tok_parser.sv]
// per-character token state: sign, digit accumulation and field splitting
`default_nettype none
module ofv_tok_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire ofv_pkg::ofv_req_t req_i,
  output ofv_pkg::ofv_tok_t      tok_o
);
  import ofv_pkg::*;

  ofv_fld_e            fld_q, fld_d;
  logic [MAG_BITS-1:0] acc_q, acc_d;
  logic                neg_q, neg_d;
  logic                empty_q, empty_d;
  logic                bad_q, bad_d;
  ofv_field_t          first_q, first_d;
  ofv_field_t          second_q, second_d;

  logic                is_slash;
  logic                is_minus;
  logic                is_digit;
  logic [MAG_BITS+3:0] acc_mul;
  ofv_field_t          cur_pre;
  ofv_field_t          cur_post;

  assign is_slash = (req_i.char_in == CHAR_SLASH);
  assign is_minus = (req_i.char_in == CHAR_MINUS);
  assign is_digit = (req_i.char_in inside {[CHAR_ZERO:CHAR_NINE]});
  assign acc_mul  = ({4'd0, acc_q} * {{MAG_BITS{1'b0}}, RADIX})
                  + {{MAG_BITS{1'b0}}, req_i.char_in[3:0] - CHAR_ZERO[3:0]};

  assign cur_pre = '{ok: !empty_q && !bad_q, neg: neg_q, mag: acc_q};

  // field counter
  always_comb begin
    fld_d = fld_q;
    if (is_slash) begin
      case (fld_q)
        FLD_POS: fld_d = FLD_TEX;
        FLD_TEX: fld_d = FLD_NRM;
        default: fld_d = fld_q;
      endcase
    end
  end

  // field contents
  always_comb begin
    acc_d    = acc_q;
    neg_d    = neg_q;
    empty_d  = empty_q;
    bad_d    = bad_q;
    first_d  = first_q;
    second_d = second_q;
    if (is_slash && fld_q != FLD_NRM) begin
      if (fld_q == FLD_POS) begin
        first_d = cur_pre;
      end else begin
        second_d = cur_pre;
      end
      acc_d   = '0;
      neg_d   = 1'b0;
      empty_d = 1'b1;
      bad_d   = 1'b0;
    end else if (is_minus && empty_q) begin
      neg_d   = 1'b1;
      empty_d = 1'b0;
    end else if (is_digit) begin
      acc_d   = (|acc_mul[MAG_BITS+3:MAG_BITS]) ? '1 : acc_mul[MAG_BITS-1:0];
      empty_d = 1'b0;
    end else begin
      bad_d   = 1'b1;
      empty_d = 1'b0;
    end
  end

  assign cur_post = '{ok: !empty_d && !bad_d, neg: neg_d, mag: acc_d};

  // fields as they stand once this character is taken
  always_comb begin
    tok_o = '0;
    case (fld_d)
      FLD_POS: begin
        tok_o.pos = cur_post;
      end
      FLD_TEX: begin
        tok_o.pos = first_d;
        tok_o.tex = cur_post;
      end
      default: begin
        tok_o.pos = first_d;
        tok_o.tex = second_d;
        tok_o.nrm = cur_post;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q    <= FLD_POS;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      empty_q  <= 1'b1;
      bad_q    <= 1'b0;
      first_q  <= '0;
      second_q <= '0;
    end else if (accept_i) begin
      if (req_i.token_end) begin
        fld_q    <= FLD_POS;
        acc_q    <= '0;
        neg_q    <= 1'b0;
        empty_q  <= 1'b1;
        bad_q    <= 1'b0;
        first_q  <= '0;
        second_q <= '0;
      end else begin
        fld_q    <= fld_d;
        acc_q    <= acc_d;
        neg_q    <= neg_d;
        empty_q  <= empty_d;
        bad_q    <= bad_d;
        first_q  <= first_d;
        second_q <= second_d;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/ofv_resolve.sv]
// maps a signed one-based field value onto a zero-based index against a count
`default_nettype none
module ofv_resolve (
  input  wire ofv_pkg::ofv_field_t               field_i,
  input  wire logic [ofv_pkg::COUNT_BITS-1:0]    count_i,
  output ofv_pkg::ofv_idx_t                      idx_o
);
  import ofv_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = COUNT_BITS'(1) << INDEX_BITS;

  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] mag;
  logic [COUNT_BITS-1:0] diff;
  logic                  in_range;

  assign cnt      = (count_i > CNT_MAX) ? CNT_MAX : count_i;
  assign mag      = COUNT_BITS'(field_i.mag);
  // positive: mag-1 < cnt; negative: cnt-mag >= 0
  assign in_range = field_i.ok && (mag != '0) && (mag <= cnt);
  assign diff     = field_i.neg ? (cnt - mag) : (mag - COUNT_BITS'(1));

  assign idx_o.present = in_range;
  assign idx_o.index   = in_range ? diff[INDEX_BITS-1:0] : '0;

endmodule
`default_nettype wire
